// ----- rtl/rnscrt_pkg.sv -----
package rnscrt_pkg;

    // word field widths
    localparam int RES_W = 8;
    localparam int VAL_W = 24;

    // the three moduli
    localparam int MOD_A = 251;
    localparam int MOD_B = 241;
    localparam int MOD_C = 239;

    // number of register stages from start to done
    localparam int STAGES = 7;

    // 256-entry table of 8-bit entries, indexed by an 8-bit value
    typedef logic [255:0][7:0] tab_t;

    // restoring reduction, only evaluated at elaboration
    function automatic logic [7:0] mod_const(input logic [23:0] x, input int q);
        logic [8:0] r;
        r = '0;
        for (int k = 23; k >= 0; k--) begin
            r = {r[7:0], x[k]};
            if (r >= 9'(q)) begin
                r = r - 9'(q);
            end
        end
        return r[7:0];
    endfunction

    // base^(q-2) mod q by square and multiply
    function automatic logic [7:0] fermat_inv(input int base, input int q);
        logic [7:0] acc;
        logic [7:0] b;
        int         e;
        acc = mod_const(24'd1, q);
        b   = mod_const(24'(base), q);
        e   = q - 2;
        for (int k = 0; k < 8; k++) begin
            if (((e >> k) & 1) != 0) begin
                acc = mod_const({16'd0, acc} * {16'd0, b}, q);
            end
            b = mod_const({16'd0, b} * {16'd0, b}, q);
        end
        return acc;
    endfunction

    // signed 8-bit pattern to its floor residue mod q
    function automatic tab_t build_red_tab(input int q);
        tab_t t;
        int   off;
        off = q - int'(mod_const(24'd128, q));
        for (int i = 0; i < 256; i++) begin
            t[i] = mod_const(24'((i ^ 128) + off), q);
        end
        return t;
    endfunction

    // unsigned 8-bit value mod q
    function automatic tab_t build_mod_tab(input int q);
        tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = mod_const(24'(i), q);
        end
        return t;
    endfunction

    // (i * k) mod q
    function automatic tab_t build_mulmod_tab(input int k, input int q);
        tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = mod_const(24'(i * k), q);
        end
        return t;
    endfunction

    // modular inverses for the mixed-radix digits
    localparam int INV_A_MOD_B  = int'(fermat_inv(int'(mod_const(24'(MOD_A), MOD_B)), MOD_B));
    localparam int INV_AB_MOD_C =
        int'(fermat_inv(int'(mod_const(24'(MOD_A * MOD_B), MOD_C)), MOD_C));

    // lookup tables
    localparam tab_t RED_TAB_A    = build_red_tab(MOD_A);
    localparam tab_t RED_TAB_B    = build_red_tab(MOD_B);
    localparam tab_t RED_TAB_C    = build_red_tab(MOD_C);
    localparam tab_t RA_MOD_B_TAB = build_mod_tab(MOD_B);
    localparam tab_t RA_MOD_C_TAB = build_mod_tab(MOD_C);
    localparam tab_t INV1_TAB     = build_mulmod_tab(INV_A_MOD_B, MOD_B);
    localparam tab_t QA_MOD_C_TAB = build_mulmod_tab(MOD_A, MOD_C);
    localparam tab_t INV2_TAB     = build_mulmod_tab(INV_AB_MOD_C, MOD_C);

    // sized constants for the datapath
    localparam logic [8:0]  QB9      = 9'(MOD_B);
    localparam logic [8:0]  QC9      = 9'(MOD_C);
    localparam logic [15:0] QA16     = 16'(MOD_A);
    localparam logic [23:0] QAB24    = 24'(MOD_A * MOD_B);
    localparam logic [23:0] PROD_ABC = 24'(MOD_A * MOD_B * MOD_C);
    localparam logic [23:0] HALF_ABC = 24'((MOD_A * MOD_B * MOD_C) / 2);
    localparam logic signed [23:0] VAL_MAX = 24'((MOD_A * MOD_B * MOD_C) / 2);
    localparam logic signed [23:0] VAL_MIN =
        24'((MOD_A * MOD_B * MOD_C) / 2 + 1 - MOD_A * MOD_B * MOD_C);

endpackage

// ----- rtl/rns_three_moduli_crt_reconstruct_unit.sv -----
// three-modulus residue to integer reconstruction (mixed-radix crt)
//
// input channel: a word (residue_a, residue_b, residue_c) is taken at every
// rising edge with start high and busy low. busy is always low, so a new
// word may enter on every cycle.
// output channel: each word gives one result on value, shown for exactly one
// cycle with done high. results leave in the order the words came in.
// done rises once the word has passed through every stage of the pipeline.
// throughput: one word per cycle, set by the seven-stage pipeline
// (table lookups, a constant multiply in stages 4 and 6, final balancing).
// value is the rebuilt integer in the balanced range around zero.
// reset: rst_n low clears all stage valid bits at once; words in flight are
// dropped and done stays low until new words reach the end.
// the receiver cannot stall: a result is presented once and not held.
module rns_three_moduli_crt_reconstruct_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rnscrt_pkg::RES_W-1:0] residue_a,
    input  logic signed [rnscrt_pkg::RES_W-1:0] residue_b,
    input  logic signed [rnscrt_pkg::RES_W-1:0] residue_c,
    output logic                                done,
    output logic signed [rnscrt_pkg::VAL_W-1:0] value
);
    import rnscrt_pkg::*;

    // stage valid bits
    logic [STAGES:1] vld_reg;
    logic [STAGES:1] vld_next;
    logic            accept;

    // stage 1: reduced residues
    logic [7:0] ra1_reg, rb1_reg, rc1_reg;
    logic [7:0] ra1_next, rb1_next, rc1_next;
    // stage 2: first difference
    logic [7:0] ra2_reg, rc2_reg, d1_2_reg, ramc2_reg;
    logic [7:0] d1_2_next, ramc2_next;
    logic [8:0] d1_sum;
    // stage 3: first mixed-radix digit
    logic [7:0] ra3_reg, rc3_reg, ramc3_reg, t1_3_reg;
    logic [7:0] t1_3_next;
    // stage 4: partial value and second difference
    logic [15:0] x1_4_reg, x1_4_next;
    logic [7:0]  d2_4_reg, d2_4_next;
    logic [8:0]  s_sum, d2_sum;
    logic [7:0]  s_mod;
    // stage 5: second mixed-radix digit
    logic [15:0] x1_5_reg;
    logic [7:0]  t2_5_reg, t2_5_next;
    // stage 6: full value
    logic [23:0] x_6_reg, x_6_next;
    // stage 7: balanced result
    logic [23:0] value_reg, value_next;

    // the pipeline never blocks
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits travel with the data
    assign vld_next = {vld_reg[STAGES-1:1], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: residue reduction by table
    always_comb
    begin
        ra1_next = RED_TAB_A[$unsigned(residue_a)];
        rb1_next = RED_TAB_B[$unsigned(residue_b)];
        rc1_next = RED_TAB_C[$unsigned(residue_c)];
    end

    // stage 2: (rb - ra) mod b, and ra mod c
    always_comb
    begin
        d1_sum = {1'b0, rb1_reg} + QB9 - {1'b0, RA_MOD_B_TAB[ra1_reg]};
        if (d1_sum >= QB9)
        begin
            d1_sum = d1_sum - QB9;
        end
        d1_2_next  = d1_sum[7:0];
        ramc2_next = RA_MOD_C_TAB[ra1_reg];
    end

    // stage 3: first digit
    assign t1_3_next = INV1_TAB[d1_2_reg];

    // stage 4: x1 = ra + a*t1, and (rc - x1) mod c
    always_comb
    begin
        x1_4_next = {8'd0, ra3_reg} + QA16 * {8'd0, t1_3_reg};
        s_sum     = {1'b0, ramc3_reg} + {1'b0, QA_MOD_C_TAB[t1_3_reg]};
        if (s_sum >= QC9)
        begin
            s_sum = s_sum - QC9;
        end
        s_mod  = s_sum[7:0];
        d2_sum = {1'b0, rc3_reg} + QC9 - {1'b0, s_mod};
        if (d2_sum >= QC9)
        begin
            d2_sum = d2_sum - QC9;
        end
        d2_4_next = d2_sum[7:0];
    end

    // stage 5: second digit
    assign t2_5_next = INV2_TAB[d2_4_reg];

    // stage 6: x = x1 + a*b*t2
    assign x_6_next = {8'd0, x1_5_reg} + QAB24 * {16'd0, t2_5_reg};

    // stage 7: fold the upper half below zero
    always_comb
    begin
        if (x_6_reg > HALF_ABC)
        begin
            value_next = x_6_reg - PROD_ABC;
        end
        else
        begin
            value_next = x_6_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ra1_reg   <= ra1_next;
        rb1_reg   <= rb1_next;
        rc1_reg   <= rc1_next;
        ra2_reg   <= ra1_reg;
        rc2_reg   <= rc1_reg;
        d1_2_reg  <= d1_2_next;
        ramc2_reg <= ramc2_next;
        ra3_reg   <= ra2_reg;
        rc3_reg   <= rc2_reg;
        ramc3_reg <= ramc2_reg;
        t1_3_reg  <= t1_3_next;
        x1_4_reg  <= x1_4_next;
        d2_4_reg  <= d2_4_next;
        x1_5_reg  <= x1_4_reg;
        t2_5_reg  <= t2_5_next;
        x_6_reg   <= x_6_next;
        value_reg <= value_next;
    end

    // result word
    assign done  = vld_reg[STAGES];
    assign value = $signed(value_reg);

    // every accepted word comes out at the end of the pipeline
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##7 done)
        else $error("accepted word did not reach the output");

    // no result without a matching input word
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 7))
        else $error("result without an accepted word");

    // both differences stay reduced
    a_d1_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (d1_2_reg < 8'(MOD_B)))
        else $error("first difference not reduced");

    a_d2_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (d2_4_reg < 8'(MOD_C)))
        else $error("second difference not reduced");

    // result lies in the balanced range
    a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (value <= VAL_MAX && value >= VAL_MIN))
        else $error("result outside balanced range");

endmodule
